// ----- sv/cds_pkg.sv -----
// Shared types, codes and constants for the calendar date stepper.
// Depends on nothing; the design files refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  // Width of the held year (two's complement).
  localparam int YEAR_BITS = 16;
  // Width of the year fields on the stream ports.
  localparam int FIELD_YEAR_W = 16;
  // Working width for year arithmetic: room for the wider operand plus carry and sign.
  localparam int EXT_W = ((YEAR_BITS > FIELD_YEAR_W) ? YEAR_BITS : FIELD_YEAR_W) + 2;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;

  typedef logic signed [YEAR_BITS-1:0]    year_t;
  typedef logic signed [EXT_W-1:0]        year_ext_t;
  typedef logic signed [FIELD_YEAR_W-1:0] field_year_t;
  typedef logic [3:0]                     month_t;
  typedef logic [4:0]                     day_t;

  typedef enum logic [2:0] {
    KIND_LOAD,
    KIND_NEXT_DAY,
    KIND_PREV_DAY,
    KIND_NEXT_MONTH,
    KIND_PREV_MONTH,
    KIND_NEXT_YEAR,
    KIND_PREV_YEAR,
    KIND_ADD_YEARS
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_LOAD,
    STATUS_YEAR_RANGE
  } status_t;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_MAR = 4'd3;
  localparam month_t MONTH_APR = 4'd4;
  localparam month_t MONTH_JUN = 4'd6;
  localparam month_t MONTH_SEP = 4'd9;
  localparam month_t MONTH_NOV = 4'd11;
  localparam month_t MONTH_DEC = 4'd12;

  localparam day_t DAY_FIRST   = 5'd1;
  localparam day_t DAY_LEAP    = 5'd29;
  localparam day_t DAY_FEB     = 5'd28;
  localparam day_t DAY_SHORT   = 5'd30;
  localparam day_t DAY_LONG    = 5'd31;

  localparam year_t RESET_YEAR = year_t'(2001);

  // Largest legal year magnitude: 2^(YEAR_BITS-1) - 1.
  localparam year_ext_t YEAR_MAX = year_ext_t'({1'b0, {(YEAR_BITS-1){1'b1}}});
  localparam year_ext_t YEAR_MIN = -YEAR_MAX;

  // Inverse of an odd number modulo 2^YEAR_BITS (Newton iteration, bits double per pass).
  function automatic logic [YEAR_BITS-1:0] odd_inverse(input logic [YEAR_BITS-1:0] d);
    logic [YEAR_BITS-1:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (YEAR_BITS'(2) - d * x);
    end
    return x;
  endfunction

  // a is a multiple of 25 exactly when a * inverse(25), kept to YEAR_BITS bits,
  // is no greater than (2^YEAR_BITS - 1) / 25.
  localparam logic [YEAR_BITS-1:0] DIV25_INV = odd_inverse(YEAR_BITS'(25));
  localparam logic [YEAR_BITS-1:0] DIV25_LIM = {YEAR_BITS{1'b1}} / YEAR_BITS'(25);

  typedef struct packed {
    kind_t       kind;
    field_year_t load_year;
    month_t      load_month;
    day_t        load_day;
    field_year_t year_delta;
  } item_t;

  typedef struct packed {
    field_year_t year;
    month_t      month;
    day_t        day;
    status_t     status;
  } result_t;

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_SHORT;
      MONTH_FEB:                                  len = leap ? DAY_LEAP : DAY_FEB;
      default:                                    len = DAY_LONG;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cds_leap.sv -----
// Leap year test for a held year (4/100/400 rule, BC years shifted by one).
// Depends on cds_pkg for the year type and the divide-by-25 constants.
`timescale 1ns / 1ps
`default_nettype none

module cds_leap (
  input  wire cds_pkg::year_t year,
  output logic                leap
);

  logic [cds_pkg::YEAR_BITS-1:0] mag;
  logic [cds_pkg::YEAR_BITS-1:0] prod;
  logic                          div25;

  // BC years test as year + 1; its magnitude is then simply ~year.
  assign mag   = year[cds_pkg::YEAR_BITS-1] ? ~year : year;
  assign prod  = mag * cds_pkg::DIV25_INV;
  assign div25 = (prod <= cds_pkg::DIV25_LIM);

  // Century years (4 and 25) are leap only when also divisible by 16.
  assign leap = (mag[1:0] == 2'b00) && (!div25 || (mag[3:0] == 4'b0000));

endmodule

`default_nettype wire

// ----- sv/cds_core.sv -----
// Date state and the combinational step logic for one beat.
// Depends on cds_pkg and cds_leap.
`timescale 1ns / 1ps
`default_nettype none

module cds_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   fire,
  input  wire cds_pkg::item_t   item,
  output cds_pkg::result_t      res
);

  cds_pkg::year_t  cur_year, cur_year_next;
  cds_pkg::month_t cur_month, cur_month_next;
  cds_pkg::day_t   cur_day, cur_day_next;

  cds_pkg::year_ext_t y_ext, ly_ext, dl_ext, y_inc, y_dec, y_sum, y_new;
  cds_pkg::month_t    m_new, m_inc, m_dec, len_month;
  cds_pkg::day_t      d_new, len;
  cds_pkg::year_t     leap_year;
  cds_pkg::status_t   status;
  logic               leap, load_ok, feb29;

  cds_leap u_leap (
    .year (leap_year),
    .leap (leap)
  );

  always_comb begin
    y_ext  = cds_pkg::year_ext_t'(cur_year);
    ly_ext = cds_pkg::year_ext_t'(item.load_year);
    dl_ext = cds_pkg::year_ext_t'(item.year_delta);

    // Year steps skip year zero.
    y_inc = y_ext + cds_pkg::year_ext_t'(1);
    if (y_inc == '0) begin
      y_inc = cds_pkg::year_ext_t'(1);
    end
    y_dec = y_ext - cds_pkg::year_ext_t'(1);
    if (y_dec == '0) begin
      y_dec = cds_pkg::year_ext_t'(-1);
    end
    y_sum = y_ext + dl_ext;
    if (y_ext < 0 && y_sum >= 0) begin
      y_sum = y_sum + cds_pkg::year_ext_t'(1);
    end else if (y_ext > 0 && y_sum <= 0) begin
      y_sum = y_sum - cds_pkg::year_ext_t'(1);
    end

    m_inc = (cur_month == cds_pkg::MONTH_DEC) ? cds_pkg::MONTH_JAN : cur_month + 4'd1;
    m_dec = (cur_month == cds_pkg::MONTH_JAN) ? cds_pkg::MONTH_DEC : cur_month - 4'd1;
    feb29 = (cur_month == cds_pkg::MONTH_FEB) && (cur_day == cds_pkg::DAY_LEAP);

    // One leap unit and one month-length lookup, shared across kinds.
    case (item.kind)
      cds_pkg::KIND_LOAD:      leap_year = ly_ext[cds_pkg::YEAR_BITS-1:0];
      cds_pkg::KIND_ADD_YEARS: leap_year = y_sum[cds_pkg::YEAR_BITS-1:0];
      default:                 leap_year = cur_year;
    endcase
    case (item.kind) inside
      cds_pkg::KIND_LOAD:                              len_month = item.load_month;
      cds_pkg::KIND_NEXT_MONTH:                        len_month = m_inc;
      cds_pkg::KIND_PREV_DAY, cds_pkg::KIND_PREV_MONTH: len_month = m_dec;
      default:                                         len_month = cur_month;
    endcase
    len = cds_pkg::month_len(len_month, leap);

    load_ok = (ly_ext != '0) && (ly_ext >= cds_pkg::YEAR_MIN) && (ly_ext <= cds_pkg::YEAR_MAX)
              && (item.load_month >= cds_pkg::MONTH_JAN) && (item.load_month <= cds_pkg::MONTH_DEC)
              && (item.load_day >= cds_pkg::DAY_FIRST) && (item.load_day <= len);

    y_new = y_ext;
    m_new = cur_month;
    d_new = cur_day;
    unique case (item.kind)
      cds_pkg::KIND_LOAD: begin
        y_new = ly_ext;
        m_new = item.load_month;
        d_new = item.load_day;
      end
      cds_pkg::KIND_NEXT_DAY: begin
        if (cur_day < len) begin
          d_new = cur_day + 5'd1;
        end else begin
          d_new = cds_pkg::DAY_FIRST;
          m_new = m_inc;
          if (cur_month == cds_pkg::MONTH_DEC) begin
            y_new = y_inc;
          end
        end
      end
      cds_pkg::KIND_PREV_DAY: begin
        if (cur_day != cds_pkg::DAY_FIRST) begin
          d_new = cur_day - 5'd1;
        end else begin
          m_new = m_dec;
          d_new = len;
          if (cur_month == cds_pkg::MONTH_JAN) begin
            y_new = y_dec;
            d_new = cds_pkg::DAY_LONG;
          end
        end
      end
      cds_pkg::KIND_NEXT_MONTH: begin
        m_new = m_inc;
        if (cur_month == cds_pkg::MONTH_DEC) begin
          y_new = y_inc;
        end else if (cur_day > len) begin
          d_new = len;
        end
      end
      cds_pkg::KIND_PREV_MONTH: begin
        m_new = m_dec;
        if (cur_month == cds_pkg::MONTH_JAN) begin
          y_new = y_dec;
        end else if (cur_day > len) begin
          d_new = len;
        end
      end
      cds_pkg::KIND_NEXT_YEAR: begin
        y_new = y_inc;
        if (feb29) begin
          m_new = cds_pkg::MONTH_MAR;
          d_new = cds_pkg::DAY_FIRST;
        end
      end
      cds_pkg::KIND_PREV_YEAR: begin
        y_new = y_dec;
        if (feb29) begin
          d_new = cds_pkg::DAY_FEB;
        end
      end
      cds_pkg::KIND_ADD_YEARS: begin
        y_new = y_sum;
        if (feb29 && !leap) begin
          m_new = cds_pkg::MONTH_MAR;
          d_new = cds_pkg::DAY_FIRST;
        end
      end
      default: ;
    endcase

    if (item.kind == cds_pkg::KIND_LOAD && !load_ok) begin
      status = cds_pkg::STATUS_BAD_LOAD;
    end else if (y_new < cds_pkg::YEAR_MIN || y_new > cds_pkg::YEAR_MAX) begin
      status = cds_pkg::STATUS_YEAR_RANGE;
    end else begin
      status = cds_pkg::STATUS_OK;
    end

    // Hold the date on any error.
    if (status == cds_pkg::STATUS_OK) begin
      cur_year_next  = y_new[cds_pkg::YEAR_BITS-1:0];
      cur_month_next = m_new;
      cur_day_next   = d_new;
    end else begin
      cur_year_next  = cur_year;
      cur_month_next = cur_month;
      cur_day_next   = cur_day;
    end

    res.year   = cds_pkg::field_year_t'(cds_pkg::year_ext_t'(cur_year_next));
    res.month  = cur_month_next;
    res.day    = cur_day_next;
    res.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= cds_pkg::RESET_YEAR;
      cur_month <= cds_pkg::MONTH_JAN;
      cur_day   <= cds_pkg::DAY_FIRST;
    end else if (fire) begin
      cur_year  <= cur_year_next;
      cur_month <= cur_month_next;
      cur_day   <= cur_day_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/calendar_date_stepper.sv -----
// Top level of the calendar date stepper: stream ports, input register, result register.
// Depends on cds_pkg and cds_core.
`timescale 1ns / 1ps
`default_nettype none

// Holds one proleptic Gregorian date (no year zero; reset value 1 January 2001)
// and answers every input beat with exactly one result beat carrying the date
// held after that beat plus a status (0 ok, 1 invalid load, 2 year out of range;
// on an error the date is left as it was). A beat waits in the input register
// while the step logic works on it, and its result is written into the result
// register once that register is free or being drained; from there it is put on
// m_tdata. One beat can be taken every cycle while the result channel is not
// stalled: the step logic reads the date state that the previous beat wrote in
// the cycle before. Throughput drops only while the result register is full and
// m_tready is low; the input register then fills and s_tready falls.

module calendar_date_stepper (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // [15:0] load_year, [19:16] load_month, [24:20] load_day, [40:25] year_delta, rest zero
  input  wire [cds_pkg::IN_DATA_W-1:0]   s_tdata,
  // [2:0] kind
  input  wire [cds_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // [15:0] year, [19:16] month, [24:20] day, [26:25] status, rest zero
  output logic [cds_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic             in_valid;
  cds_pkg::item_t   item;
  cds_pkg::result_t step_res;
  cds_pkg::result_t res;
  logic             fire;
  logic             s_take;

  // Step the held beat when the result register is free or draining this cycle.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_take   = s_tvalid && s_tready;

  // Input register: capture the beat's fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      item.kind       <= cds_pkg::kind_t'(s_tuser[2:0]);
      item.load_year  <= s_tdata[15:0];
      item.load_month <= s_tdata[19:16];
      item.load_day   <= s_tdata[24:20];
      item.year_delta <= s_tdata[40:25];
    end
  end

  cds_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (step_res)
  );

  // Result register: hold until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_res;
    end
  end

  assign m_tdata = {5'b00000, res.status, res.day, res.month, res.year};

endmodule

`default_nettype wire

// ----- sim/date_checker.sv -----
// Date checker for the calendar date stepper: watches both stream channels,
// predicts each result from the beats taken in and compares it field by field.
// Depends on cds_pkg for the field types and the kind and status codes.
`timescale 1ns / 1ps

module date_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  input  wire                            s_tready,
  // [15:0] load_year, [19:16] load_month, [24:20] load_day, [40:25] year_delta
  input  wire [cds_pkg::IN_DATA_W-1:0]   s_tdata,
  // [2:0] kind
  input  wire [cds_pkg::IN_USER_W-1:0]   s_tuser,
  input  wire                            m_tvalid,
  input  wire                            m_tready,
  // [15:0] year, [19:16] month, [24:20] day, [26:25] status
  input  wire [cds_pkg::OUT_DATA_W-1:0]  m_tdata,
  output int                             mismatches,
  output int                             pending,
  output int                             checked,
  output int                             bad_loads,
  output int                             range_hits
);
  import cds_pkg::*;

  localparam longint YEAR_TOP = (longint'(1) << (YEAR_BITS - 1)) - 1;
  localparam int REPORT_LIMIT = 10;

  longint  held_year;
  int      held_month;
  int      held_day;
  result_t expected_dates[$];
  int      errors;
  int      n_checked;
  int      n_bad;
  int      n_range;

  function automatic bit leap_year(input longint y);
    longint t;
    t = (y < 0) ? y + 1 : y;
    return (t % 4 == 0 && t % 100 != 0) || (t % 400 == 0);
  endfunction

  function automatic int days_in(input int m, input longint y);
    int len;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
      len = DAY_SHORT;
    else if (m == MONTH_FEB)
      len = leap_year(y) ? DAY_LEAP : DAY_FEB;
    else
      len = DAY_LONG;
    return len;
  endfunction

  function automatic bit year_legal(input longint y);
    return y != 0 && y >= -YEAR_TOP && y <= YEAR_TOP;
  endfunction

  // Apply one beat to the held date and return the result it must produce.
  function automatic result_t next_date(input kind_t kind, input field_year_t ly,
                                        input month_t lm, input day_t ld,
                                        input field_year_t dy);
    longint  y;
    longint  ny;
    longint  load_y;
    int      m;
    int      d;
    status_t st;
    result_t r;
    y = held_year;
    m = held_month;
    d = held_day;
    st = STATUS_OK;
    case (kind)
      KIND_LOAD: begin
        load_y = ly;
        if (!year_legal(load_y) || lm < MONTH_JAN || lm > MONTH_DEC ||
            ld < DAY_FIRST || ld > days_in(lm, load_y)) begin
          st = STATUS_BAD_LOAD;
        end else begin
          y = load_y;
          m = lm;
          d = ld;
        end
      end
      KIND_NEXT_DAY: begin
        if (d < days_in(m, y)) begin
          d++;
        end else begin
          d = DAY_FIRST;
          m++;
          if (m > MONTH_DEC) begin
            m = MONTH_JAN;
            y++;
            if (y == 0) y = 1;
          end
        end
      end
      KIND_PREV_DAY: begin
        if (d != DAY_FIRST) begin
          d--;
        end else begin
          m--;
          if (m < MONTH_JAN) begin
            m = MONTH_DEC;
            y--;
            if (y == 0) y = -1;
          end
          if (y >= -YEAR_TOP) d = days_in(m, y);
        end
      end
      KIND_NEXT_MONTH: begin
        m++;
        if (m > MONTH_DEC) begin
          m = MONTH_JAN;
          y++;
          if (y == 0) y = 1;
        end
        if (d > days_in(m, y)) d = days_in(m, y);
      end
      KIND_PREV_MONTH: begin
        m--;
        if (m < MONTH_JAN) begin
          m = MONTH_DEC;
          y--;
          if (y == 0) y = -1;
        end
        if (d > days_in(m, y)) d = days_in(m, y);
      end
      KIND_NEXT_YEAR: begin
        if (m == MONTH_FEB && d == DAY_LEAP) begin
          m = MONTH_MAR;
          d = DAY_FIRST;
        end
        y++;
        if (y == 0) y = 1;
      end
      KIND_PREV_YEAR: begin
        if (m == MONTH_FEB && d == DAY_LEAP) d = DAY_FEB;
        y--;
        if (y == 0) y = -1;
      end
      KIND_ADD_YEARS: begin
        // skip year zero in whichever direction the sum crosses it
        ny = y + longint'(dy);
        if (y < 0 && ny >= 0) ny++;
        if (y > 0 && ny <= 0) ny--;
        y = ny;
        if (m == MONTH_FEB && d == DAY_LEAP && !leap_year(y)) begin
          m = MONTH_MAR;
          d = DAY_FIRST;
        end
      end
    endcase
    if (st == STATUS_OK && !year_legal(y)) st = STATUS_YEAR_RANGE;
    if (st == STATUS_OK) begin
      held_year = y;
      held_month = m;
      held_day = d;
    end
    r.year = field_year_t'(held_year);
    r.month = month_t'(held_month);
    r.day = day_t'(held_day);
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    result_t got_r;
    if (rst) begin
      held_year = longint'(RESET_YEAR);
      held_month = MONTH_JAN;
      held_day = DAY_FIRST;
      expected_dates.delete();
      errors = 0;
      n_checked = 0;
      n_bad = 0;
      n_range = 0;
    end else begin
      // check the result beat first: it always belongs to an older input beat
      if (m_tvalid && m_tready) begin
        got_r.year = field_year_t'(m_tdata[15:0]);
        got_r.month = m_tdata[19:16];
        got_r.day = m_tdata[24:20];
        got_r.status = status_t'(m_tdata[26:25]);
        if (expected_dates.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("date_checker: unexpected result %0d-%0d-%0d status %0d",
                     got_r.year, got_r.month, got_r.day, got_r.status);
        end else begin
          exp_r = expected_dates.pop_front();
          n_checked++;
          if (got_r != exp_r || m_tdata[31:27] != 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"date_checker: result %0d expected %0d-%0d-%0d status %0d,",
                        " got %0d-%0d-%0d status %0d pad %h"},
                       n_checked, exp_r.year, exp_r.month, exp_r.day, exp_r.status,
                       got_r.year, got_r.month, got_r.day, got_r.status,
                       m_tdata[31:27]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        exp_r = next_date(kind_t'(s_tuser[2:0]), field_year_t'(s_tdata[15:0]),
                          s_tdata[19:16], s_tdata[24:20], field_year_t'(s_tdata[40:25]));
        if (exp_r.status == STATUS_BAD_LOAD) n_bad++;
        if (exp_r.status == STATUS_YEAR_RANGE) n_range++;
        expected_dates.push_back(exp_r);
      end
    end
    mismatches <= errors;
    pending <= expected_dates.size();
    checked <= n_checked;
    bad_loads <= n_bad;
    range_hits <= n_range;
  end

endmodule

// ----- sim/tb.sv -----
// Top of the calendar date stepper testbench: clock, reset, stimulus and verdict.
// Depends on cds_pkg, calendar_date_stepper and date_checker.
`timescale 1ns / 1ps

module tb;
  import cds_pkg::*;

  // Random beats after the directed part.
  localparam int RANDOM_BEATS = 550;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Percent of cycles in which each side idles.
  localparam int IDLE_PCT = 14;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  wire                   s_tready;
  // [15:0] load_year, [19:16] load_month, [24:20] load_day, [40:25] year_delta
  logic [IN_DATA_W-1:0]  s_tdata;
  // [2:0] kind
  logic [IN_USER_W-1:0]  s_tuser;
  wire                   m_tvalid;
  logic                  m_tready;
  // [15:0] year, [19:16] month, [24:20] day, [26:25] status
  wire  [OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int pending;
  int checked;
  int bad_loads;
  int range_hits;

  // Set during the long stretch in which neither side idles.
  bit calm;
  int beats_sent;
  int directed_beats;
  int stall_cycles;

  calendar_date_stepper uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  date_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .bad_loads  (bad_loads),
    .range_hits (range_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random, except during the calm stretch.
  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: no beat moved for %0d cycles, %0d results still due",
                 STALL_LIMIT, pending);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Drive one input beat at the falling edge, possibly after a few idle cycles,
  // and hold it until the block takes it at a rising edge.
  task automatic send_beat(input kind_t kind, input int y, input int m, input int d,
                           input int delta);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tuser <= kind;
    s_tdata <= {7'd0, delta[15:0], d[4:0], m[3:0], y[15:0]};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  initial begin
    int pick;
    int y;
    int m;
    int d;
    int delta;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    calm = 1'b0;
    beats_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part: leap rules, Feb 29 on year steps, year zero, clamping,
    // rejected loads and both ends of the year range.
    send_beat(KIND_NEXT_DAY, 0, 0, 0, 0);          // step off the reset date
    send_beat(KIND_LOAD, 2000, 2, 29, 0);          // leap by the 400 rule
    send_beat(KIND_NEXT_YEAR, 0, 0, 0, 0);         // Feb 29 moves to Mar 1
    send_beat(KIND_LOAD, 1900, 2, 29, 0);          // century year, not leap: rejected
    send_beat(KIND_LOAD, 2004, 2, 29, 0);
    send_beat(KIND_PREV_YEAR, 0, 0, 0, 0);         // Feb 29 falls back to Feb 28
    send_beat(KIND_LOAD, -1, 12, 31, 0);
    send_beat(KIND_NEXT_DAY, 0, 0, 0, 0);          // 1 BC to AD 1
    send_beat(KIND_PREV_DAY, 0, 0, 0, 0);          // and back
    send_beat(KIND_LOAD, -1, 2, 29, 0);            // shifted BC leap year
    send_beat(KIND_ADD_YEARS, 0, 0, 0, 0);         // zero delta keeps Feb 29
    send_beat(KIND_ADD_YEARS, 0, 0, 0, 1);         // skips year zero, lands on Mar 1
    send_beat(KIND_LOAD, 1, 1, 31, 0);
    send_beat(KIND_PREV_MONTH, 0, 0, 0, 0);        // month step across year zero
    send_beat(KIND_NEXT_MONTH, 0, 0, 0, 0);
    send_beat(KIND_NEXT_MONTH, 0, 0, 0, 0);        // Jan 31 clamps to Feb 28
    send_beat(KIND_LOAD, 0, 1, 1, 0);              // year zero
    send_beat(KIND_LOAD, 2001, 0, 1, 0);           // month zero
    send_beat(KIND_LOAD, 2001, 15, 31, 0);         // month and day fields at their maximum
    send_beat(KIND_LOAD, 2001, 4, 31, 0);          // day past a short month
    send_beat(KIND_LOAD, 2001, 1, 0, 0);           // day zero
    send_beat(KIND_LOAD, -32768, 1, 1, 0);         // year below the legal range
    send_beat(KIND_LOAD, 32767, 12, 31, 0);
    send_beat(KIND_NEXT_DAY, 0, 0, 0, 0);          // overflow at the top
    send_beat(KIND_ADD_YEARS, 0, 0, 0, 32767);
    send_beat(KIND_LOAD, -32767, 1, 1, 0);
    send_beat(KIND_PREV_MONTH, 0, 0, 0, 0);        // overflow at the bottom
    send_beat(KIND_ADD_YEARS, 0, 0, 0, -32768);
    directed_beats = beats_sent;

    // Random part: mostly legal dates walked by single steps, with some
    // year additions, and a share of loads with every field random.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= 200 && i < 330);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       y = $urandom_range(1, 3);
          1:       y = 32767 - $urandom_range(0, 3);
          2:       y = $urandom_range(1, 32767);
          default: y = 1890 + $urandom_range(0, 230);
        endcase
        if ($urandom_range(0, 1)) y = -y;
        if ($urandom_range(0, 3) == 0) begin
          // aim at Feb 29 of a year that passes the divide-by-four test
          m = 2;
          d = 29;
          y = 4 * $urandom_range(1, 8191);
          if ($urandom_range(0, 1)) y = -y - 1;
        end else begin
          d = $urandom_range(0, 1) ? $urandom_range(1, 28) : $urandom_range(28, 31);
        end
        send_beat(KIND_LOAD, y, m, d, $urandom);
      end else if (pick < 16) begin
        send_beat(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 86) begin
        send_beat(kind_t'($urandom_range(1, 6)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0:       delta = $urandom_range(0, 10) - 5;
          1:       delta = $urandom_range(0, 6000) - 3000;
          2:       delta = $urandom_range(0, 1) ? 32767 : -32768;
          default: delta = $urandom;
        endcase
        send_beat(KIND_ADD_YEARS, $urandom, $urandom, $urandom, delta);
      end
    end
    calm = 1'b0;

    // Drop valid, let the checker see the last beat, then drain the results.
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d beats driven (%0d directed), %0d results checked",
             beats_sent, directed_beats, checked);
    $display("tb: %0d rejected loads, %0d year range errors, %0d mismatches",
             bad_loads, range_hits, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
